// ===== src/dcrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_pkg
// Shared widths, result kinds and the result bundle of the delimited command
// receive buffer.
// ----------------------------------------------------------------------------
package dcrb_pkg;

    localparam int DATA_W    = 8;
    localparam int LEN_W     = 7;
    localparam int LEVEL_W   = 7;
    localparam int KIND_W    = 2;
    localparam int DEPTH_DEF = 64;

    localparam logic [DATA_W-1:0] DELIM_RESET = 8'd13;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK   = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic               last;
        logic               accepted;
        logic               complete;
        logic               cmd_ready;
        logic [LEVEL_W-1:0] level;
    } t_result;

endpackage

// ===== src/dcrb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dcrb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_ctrl
// Circular buffer pointers, delimiter tracking and the read sequencer that
// rescans the store through the single RAM read port and streams commands.
// ----------------------------------------------------------------------------
module dcrb_ctrl #(
    parameter int DEPTH = dcrb_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_op,
    input  logic [dcrb_pkg::DATA_W-1:0]  i_rx_byte,
    input  logic [dcrb_pkg::LEN_W-1:0]   i_max_len,
    input  logic [dcrb_pkg::DATA_W-1:0]  i_delim,
    input  logic [dcrb_pkg::DATA_W-1:0]  i_rdata,
    output logic                         o_we,
    output logic [$clog2(DEPTH)-1:0]     o_waddr,
    output logic [dcrb_pkg::DATA_W-1:0]  o_wdata,
    output logic                         o_re,
    output logic [$clog2(DEPTH)-1:0]     o_raddr,
    output dcrb_pkg::t_result            o_res
);

    import dcrb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(2 * DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_fill;
    logic [PW-1:0]   r_head;
    logic            r_dvalid;
    logic [PW-1:0]   r_dpos;
    logic [PW-1:0]   r_addr;
    logic [PW-1:0]   r_emit_addr;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_n;
    logic            r_whole;
    t_result         r_res;

    logic            accept;
    logic            room;
    logic            rx_hit;
    logic            rd_hit;
    logic [SW-1:0]   tail_sum;
    logic [PW-1:0]   tail;
    logic [CW-1:0]   dpos1;
    logic [CW-1:0]   n_take;
    logic            whole;
    logic [SW-1:0]   head_sum;
    logic [PW-1:0]   new_head;
    logic [PW-1:0]   addr_inc;
    logic            emit_last;

    always_comb begin
        accept   = i_start && (r_state == ST_IDLE);
        room     = r_fill < CW'(DEPTH);
        rx_hit   = i_rx_byte == i_delim;
        rd_hit   = i_rdata == i_delim;

        tail_sum = SW'(r_head) + SW'(r_fill);
        tail     = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);

        // take up to and including the first delimiter, capped by max_len
        dpos1    = CW'(r_dpos) + CW'(1);
        n_take   = (LEN_W'(dpos1) > i_max_len) ? CW'(i_max_len) : dpos1;
        whole    = n_take == dpos1;

        head_sum = SW'(r_head) + SW'(n_take);
        new_head = (head_sum >= SW'(DEPTH)) ? PW'(head_sum - SW'(DEPTH)) : PW'(head_sum);

        addr_inc  = (r_addr == PW'(DEPTH - 1)) ? '0 : r_addr + PW'(1);
        emit_last = (r_idx + CW'(1)) == r_n;
    end

    assign o_busy  = r_state != ST_IDLE;
    assign o_we    = accept && (i_op == OP_RECEIVE) && room;
    assign o_waddr = tail;
    assign o_wdata = i_rx_byte;
    assign o_re    = (r_state == ST_SCAN_RD) || (r_state == ST_EMIT);
    assign o_raddr = r_addr;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_head      <= '0;
            r_dvalid    <= 1'b0;
            r_dpos      <= '0;
            r_idx       <= '0;
            r_res       <= '0;
        end else begin
            r_res.valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_op == OP_RECEIVE) begin
                            if (room) begin
                                r_fill <= r_fill + CW'(1);
                                if (!r_dvalid && rx_hit) begin
                                    r_dvalid <= 1'b1;
                                    r_dpos   <= r_fill[PW-1:0];
                                end
                            end
                            r_res.valid     <= 1'b1;
                            r_res.kind      <= KIND_ACK;
                            r_res.last      <= 1'b1;
                            r_res.accepted  <= room;
                            r_res.complete  <= 1'b0;
                            r_res.cmd_ready <= r_dvalid || (room && rx_hit);
                            r_res.level     <= room ? LEVEL_W'(r_fill + CW'(1))
                                                    : LEVEL_W'(r_fill);
                        end else if (!r_dvalid || (i_max_len == '0)) begin
                            r_res.valid     <= 1'b1;
                            r_res.kind      <= KIND_EMPTY;
                            r_res.last      <= 1'b1;
                            r_res.accepted  <= 1'b0;
                            r_res.complete  <= 1'b0;
                            r_res.cmd_ready <= r_dvalid;
                            r_res.level     <= LEVEL_W'(r_fill);
                        end else begin
                            // drop the command up front, rescan the rest, then stream it
                            r_n         <= n_take;
                            r_whole     <= whole;
                            r_emit_addr <= r_head;
                            r_head      <= new_head;
                            r_addr      <= new_head;
                            r_fill      <= r_fill - n_take;
                            r_dvalid    <= 1'b0;
                            r_dpos      <= '0;
                            r_idx       <= '0;
                            r_state     <= ST_SCAN_RD;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    if (r_idx == r_fill) begin
                        r_addr  <= r_emit_addr;
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK: begin
                    if (rd_hit) begin
                        r_dvalid <= 1'b1;
                        r_dpos   <= r_idx[PW-1:0];
                        r_addr   <= r_emit_addr;
                        r_idx    <= '0;
                        r_state  <= ST_EMIT;
                    end else begin
                        r_idx    <= r_idx + CW'(1);
                        r_addr   <= addr_inc;
                        r_state  <= ST_SCAN_RD;
                    end
                end
                ST_EMIT: begin
                    // read data and the result strobe are both registered, so they land together
                    r_idx           <= r_idx + CW'(1);
                    r_addr          <= addr_inc;
                    r_res.valid     <= 1'b1;
                    r_res.kind      <= KIND_BYTE;
                    r_res.last      <= emit_last;
                    r_res.accepted  <= 1'b0;
                    r_res.complete  <= emit_last && r_whole;
                    r_res.cmd_ready <= r_dvalid;
                    r_res.level     <= LEVEL_W'(r_fill);
                    if (emit_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/delimited_command_receive_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_command_receive_buffer_top
// Byte receive buffer that hands out delimiter-terminated commands.
// ----------------------------------------------------------------------------
// A receive (op 0) never raises busy and its acknowledge strobes on the
// next cycle; back-to-back receives run at one per cycle. A read (op 1) that
// finds no stored delimiter or a zero max_len strobes one empty result on the
// next cycle. Otherwise busy rises and the rescan reads the remaining bytes
// one at a time through the single RAM read port, in a read state and a
// check state each, until it finds the next delimiter or runs out; the
// command bytes then stream one per cycle, and the last one strobes in the
// same cycle that busy falls. Results carry no backpressure: each is valid
// for exactly one cycle on o_res_valid.
// ----------------------------------------------------------------------------
module delimited_command_receive_buffer_top #(
    parameter int DEPTH = dcrb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [dcrb_pkg::DATA_W-1:0]   i_rx_byte,
    input  logic [dcrb_pkg::LEN_W-1:0]    i_max_len,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcrb_pkg::DATA_W-1:0]   i_cfg_data,
    output logic                          o_res_valid,
    output logic [dcrb_pkg::KIND_W-1:0]   o_kind,
    output logic [dcrb_pkg::DATA_W-1:0]   o_data,
    output logic                          o_last,
    output logic                          o_accepted,
    output logic                          o_complete,
    output logic                          o_cmd_ready,
    output logic [dcrb_pkg::LEVEL_W-1:0]  o_level
);

    import dcrb_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_delim;
    logic              we;
    logic [PW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    t_result           res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg_valid) begin
            r_delim <= i_cfg_data;
        end
    end

    dcrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dcrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_op      (i_op),
        .i_rx_byte (i_rx_byte),
        .i_max_len (i_max_len),
        .i_delim   (r_delim),
        .i_rdata   (rdata),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_re      (re),
        .o_raddr   (raddr),
        .o_res     (res)
    );

    assign o_res_valid = res.valid;
    assign o_kind      = res.kind;
    assign o_data      = (res.kind == KIND_BYTE) ? rdata : '0;
    assign o_last      = res.last;
    assign o_accepted  = res.accepted;
    assign o_complete  = res.complete;
    assign o_cmd_ready = res.cmd_ready;
    assign o_level     = res.level;

endmodule

// ===== tb/sv/dcrb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_checker
// Watches the command, configuration and result channels of the delimited
// command receive buffer. Keeps its own copy of the line store, predicts the
// result stream of every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module dcrb_checker #(
    parameter int DEPTH = dcrb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_op,
    input  logic [dcrb_pkg::DATA_W-1:0]   i_rx_byte,
    input  logic [dcrb_pkg::LEN_W-1:0]    i_max_len,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [dcrb_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                          o_res_valid,
    input  logic [dcrb_pkg::KIND_W-1:0]   o_kind,
    input  logic [dcrb_pkg::DATA_W-1:0]   o_data,
    input  logic                          o_last,
    input  logic                          o_accepted,
    input  logic                          o_complete,
    input  logic                          o_cmd_ready,
    input  logic [dcrb_pkg::LEVEL_W-1:0]  o_level,
    output int                            fail_count,
    output int                            pending,
    output int                            checked,
    output int                            refused,
    output int                            whole_cmds,
    output int                            stored,
    output logic                          has_delim
);

    import dcrb_pkg::*;

    typedef struct {
        t_kind               kind;
        logic [DATA_W-1:0]   data;
        logic                last;
        logic                accepted;
        logic                complete;
        logic                cmd_ready;
        logic [LEVEL_W-1:0]  level;
    } t_line_result;

    t_line_result        want_q[$];
    logic [DATA_W-1:0]   line_mem [DEPTH];
    int                  fill;
    bit                  delim_seen;
    int                  delim_idx;
    logic [DATA_W-1:0]   delim_char;

    // cmd_ready and level always reflect the state after the step
    function automatic void push_result(t_kind k, logic [DATA_W-1:0] d, logic lst,
                                        logic acc, logic cpl);
        t_line_result r;
        r.kind      = k;
        r.data      = d;
        r.last      = lst;
        r.accepted  = acc;
        r.complete  = cpl;
        r.cmd_ready = delim_seen;
        r.level     = LEVEL_W'(fill);
        want_q.push_back(r);
    endfunction

    function automatic void rescan_delim();
        int i;
        delim_seen = 1'b0;
        delim_idx  = 0;
        for (i = 0; i < fill && !delim_seen; i++) begin
            if (line_mem[i] == delim_char) begin
                delim_seen = 1'b1;
                delim_idx  = i;
            end
        end
    endfunction

    function automatic void predict_command(t_op o, logic [DATA_W-1:0] b,
                                            logic [LEN_W-1:0] lim);
        logic [DATA_W-1:0] taken [DEPTH];
        int                n;
        int                i;
        bit                whole;
        if (o == OP_RECEIVE) begin
            if (fill < DEPTH) begin
                line_mem[fill] = b;
                if (!delim_seen && b == delim_char) begin
                    delim_seen = 1'b1;
                    delim_idx  = fill;
                end
                fill++;
                push_result(KIND_ACK, '0, 1'b1, 1'b1, 1'b0);
            end else begin
                refused++;
                push_result(KIND_ACK, '0, 1'b1, 1'b0, 1'b0);
            end
        end else if (!delim_seen || lim == 0) begin
            push_result(KIND_EMPTY, '0, 1'b1, 1'b0, 1'b0);
        end else begin
            n = delim_idx + 1;
            if (n > lim)
                n = lim;
            if (n > fill)
                n = fill;
            whole = n > delim_idx;
            for (i = 0; i < n; i++)
                taken[i] = line_mem[i];
            for (i = n; i < fill; i++)
                line_mem[i-n] = line_mem[i];
            fill -= n;
            rescan_delim();
            if (whole)
                whole_cmds++;
            for (i = 0; i < n; i++)
                push_result(KIND_BYTE, taken[i], i == n - 1, 1'b0, (i == n - 1) && whole);
        end
    endfunction

    function automatic void cmp_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: result %0d field %s expected 0x%0h actual 0x%0h",
                     $time, checked, name, want, got);
        end
    endfunction

    function automatic void check_result();
        t_line_result w;
        if (want_q.size() == 0) begin
            fail_count++;
            $display("%0t ns: result with nothing expected, %s kind %0d data 0x%0h",
                     $time, "expected none actual", o_kind, o_data);
        end else begin
            w = want_q.pop_front();
            cmp_field("kind",      DATA_W'(w.kind),      DATA_W'(o_kind));
            cmp_field("data",      w.data,               o_data);
            cmp_field("last",      DATA_W'(w.last),      DATA_W'(o_last));
            cmp_field("accepted",  DATA_W'(w.accepted),  DATA_W'(o_accepted));
            cmp_field("complete",  DATA_W'(w.complete),  DATA_W'(o_complete));
            cmp_field("cmd_ready", DATA_W'(w.cmd_ready), DATA_W'(o_cmd_ready));
            cmp_field("level",     DATA_W'(w.level),     DATA_W'(o_level));
        end
        checked++;
    endfunction

    // results are compared before a new command is queued; a command's first
    // result never shows on the edge that accepts it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill       = 0;
            delim_seen = 1'b0;
            delim_idx  = 0;
            delim_char = DELIM_RESET;
            want_q.delete();
        end else begin
            if (o_res_valid)
                check_result();
            if (i_cfg_valid && o_cfg_ready)
                delim_char = i_cfg_data;
            if (start && !busy)
                predict_command(t_op'(i_op), i_rx_byte, i_max_len);
        end
        pending   = want_q.size();
        stored    = fill;
        has_delim = delim_seen;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives receive and read commands into the delimited command receive buffer
// under several delimiter settings, with random gaps between commands, and
// lets dcrb_checker score every result.
// ----------------------------------------------------------------------------
module tb_top;
    import dcrb_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_op;
    logic [DATA_W-1:0]   i_rx_byte;
    logic [LEN_W-1:0]    i_max_len;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [DATA_W-1:0]   i_cfg_data;
    logic                o_res_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [DATA_W-1:0]   o_data;
    logic                o_last;
    logic                o_accepted;
    logic                o_complete;
    logic                o_cmd_ready;
    logic [LEVEL_W-1:0]  o_level;

    int                  fail_count;
    int                  pending;
    int                  checked;
    int                  refused;
    int                  whole_cmds;
    int                  stored;
    logic                has_delim;

    int                  sent;
    bit                  gappy;
    logic [DATA_W-1:0]   cur_delim;

    delimited_command_receive_buffer_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (i_max_len),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last),
        .o_accepted  (o_accepted),
        .o_complete  (o_complete),
        .o_cmd_ready (o_cmd_ready),
        .o_level     (o_level)
    );

    dcrb_checker #(
        .DEPTH(DEPTH)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (i_max_len),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last),
        .o_accepted  (o_accepted),
        .o_complete  (o_complete),
        .o_cmd_ready (o_cmd_ready),
        .o_level     (o_level),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .refused     (refused),
        .whole_cmds  (whole_cmds),
        .stored      (stored),
        .has_delim   (has_delim)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int p;
        if (!gappy)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    // with start still high, so back-to-back commands keep it asserted
    task automatic send_item(t_op o, logic [DATA_W-1:0] b, logic [LEN_W-1:0] lim);
        int g;
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_op      <= o;
        i_rx_byte <= b;
        i_max_len <= lim;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        sent++;
    endtask

    // never let the store fill up without a delimiter, or it would lock for good
    task automatic send_byte(logic [DATA_W-1:0] b);
        if (!has_delim && stored == DEPTH - 1)
            b = cur_delim;
        send_item(OP_RECEIVE, b, LEN_W'($urandom_range(0, 64)));
    endtask

    task automatic send_read(logic [LEN_W-1:0] lim);
        send_item(OP_READ, DATA_W'($urandom_range(0, 255)), lim);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
    endtask

    task automatic write_delim(logic [DATA_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_delim = v;
    endtask

    task automatic drain();
        settle();
        while (stored != 0) begin
            if (!has_delim)
                send_byte(cur_delim);
            send_read(64);
        end
        settle();
    endtask

    // 63 plain bytes, a delimiter in the top slot, two refused bytes, then one
    // read that takes out the whole store
    task automatic fill_store();
        logic [DATA_W-1:0] b;
        drain();
        repeat (DEPTH - 1) begin
            b = DATA_W'($urandom_range(0, 255));
            if (b == cur_delim)
                b ^= 8'h01;
            send_byte(b);
        end
        send_byte(cur_delim);
        send_byte(DATA_W'($urandom_range(0, 255)));
        send_byte(cur_delim);
        send_read(64);
    endtask

    task automatic random_phase(int quota);
        int target;
        int r;
        int k;
        target = sent + quota;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                // one framed command, mostly short; a few lack the delimiter
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
                repeat (k)
                    send_byte(DATA_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) != 0)
                    send_byte(cur_delim);
            end else if (r < 85) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_read(64);
                else if (r < 80)
                    send_read(LEN_W'($urandom_range(1, 8)));
                else if (r < 90)
                    send_read(0);
                else
                    send_read(LEN_W'($urandom_range(0, 64)));
            end else if ($urandom_range(0, 1) == 0) begin
                send_byte(DATA_W'($urandom_range(0, 255)));
            end else begin
                send_read(LEN_W'($urandom_range(0, 64)));
            end
        end
    endtask

    initial begin
        int                p;
        int                k;
        logic [DATA_W-1:0] v;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_RECEIVE;
        i_rx_byte   = '0;
        i_max_len   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        sent        = 0;
        gappy       = 1'b1;
        cur_delim   = DELIM_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, zero length, extremes, partial reads
        send_read(64);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_delim);
        send_read(0);
        send_read(64);
        send_byte("A");
        send_byte("B");
        send_byte("C");
        send_byte(cur_delim);
        send_byte("D");
        send_byte(cur_delim);
        send_read(2);
        send_read(64);
        send_read(1);
        send_read(1);
        send_byte("x");
        send_read(64);
        drain();

        for (p = 0; p < 5; p++) begin
            v = (p == 0) ? 8'hFF :
                (p == 1) ? 8'h00 :
                (p == 3) ? DELIM_RESET : DATA_W'($urandom_range(1, 254));
            gappy = (p != 2);
            write_delim(v);
            if (p == 1 || p == 3) begin
                fill_store();
                random_phase(15);
            end else begin
                random_phase(82);
            end
        end

        start <= 1'b0;
        for (k = 0; k < 20000 && pending != 0; k++)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (pending != 0)
            $display("tb_top: %0d expected results never arrived", pending);
        $display("tb_top: %0d commands over 6 delimiter settings, %0d results checked",
                 sent, checked);
        $display("tb_top: %0d whole commands read out, %0d bytes refused on a full store",
                 whole_cmds, refused);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
